FILE: design/pbfs_pkg.sv
package pbfs_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned OFS_W   = 6;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned WIDTH_W = 7;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned NEXT_W  = 17;
  // Largest start address: 65535 records of 64 bits.
  localparam int unsigned START_W = POS_W + OFS_W;
  localparam int unsigned END_W   = START_W + 1;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [1:0]         req_t;

  localparam req_t REQ_READ_FIELD   = 2'd0;
  localparam req_t REQ_WRITE_FIELD  = 2'd1;
  localparam req_t REQ_READ_RECORD  = 2'd2;
  localparam req_t REQ_WRITE_RECORD = 2'd3;

  localparam logic CFG_BITMAP_BITS  = 1'b0;
  localparam logic CFG_RECORD_WIDTH = 1'b1;

  localparam logic [SIZE_W-1:0]  BITMAP_RESET = 17'd65536;
  localparam width_t             RECORD_RESET = 7'd8;
  localparam width_t             FULL_WIDTH   = 7'd64;

  // Low w bits set; w of 64 and above gives all ones.
  function automatic word_t width_mask(input width_t w);
    word_t m;
    if (w >= FULL_WIDTH) begin
      m = '1;
    end else begin
      m = (word_t'(1) << w[OFS_W-1:0]) - word_t'(1);
    end
    return m;
  endfunction

endpackage

FILE: design/packed_bit_field_store.sv
// Bit-addressed store of NUM_WORDS 64-bit words kept in one single-port RAM.
// Command channel: a request transfers at a rising edge with start high and
// busy low. req_type_i picks field read, field write, record read or record
// write; position_i is a bit index for field ops and a record index for
// record ops (start bit = index * record width). A field of 0 to 64 bits may
// straddle two words.
// Result channel: done_o is high for exactly one cycle with read_value_o,
// next_position_o and status_o; the receiver cannot stall, so it must take
// the transfer in that cycle. status_o high means out of range, store intact.
// Sequencing: done_o rises as the block returns to idle, and busy drops
// together with done_o, so the next request can transfer at the edge at
// which the result transfers; no new request is taken before the last one
// is through. The single RAM port sets the steps: CALC for the record
// multiply, then CHECK for the range check with the low-word read, RD1 for
// the high-word read, RD2 for the low-word write and WR1 for the high-word
// write, one access per cycle, plus IDLE, where the request transfers.
// Configuration: cfg_we_i writes register cfg_idx_i (0 bitmap_bits,
// 1 record_width) at once; write only while busy is low.
// Reset: registers take their defaults (65536 bits, 8-bit records) and a
// clearing pass zeroes the RAM one word per cycle, all NUM_WORDS words, with
// busy held high. Configuration writes are taken during the pass.
module packed_bit_field_store #(
  parameter int unsigned NUM_WORDS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  pbfs_pkg::req_t              req_type_i,
  input  logic [pbfs_pkg::POS_W-1:0]  position_i,
  input  pbfs_pkg::width_t            field_width_i,
  input  pbfs_pkg::word_t             write_value_i,
  output logic                        done_o,
  output pbfs_pkg::word_t             read_value_o,
  output logic [pbfs_pkg::NEXT_W-1:0] next_position_o,
  output logic                        status_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [pbfs_pkg::SIZE_W-1:0] cfg_wdata_i
);
  import pbfs_pkg::*;

  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned WI_W = START_W - OFS_W;
  localparam logic [END_W-1:0] CAP = END_W'(NUM_WORDS * WORD_W);
  localparam logic [WI_W:0] WC_CMP = (WI_W + 1)'(NUM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_RD1   = 3'd4;
  localparam logic [2:0] ST_RD2   = 3'd5;
  localparam logic [2:0] ST_WR1   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [AW-1:0] clr_cnt_q;
  logic done_q;

  logic [SIZE_W-1:0] bitmap_q;
  width_t record_q;

  // request payload
  req_t type_q;
  logic [POS_W-1:0] pos_q;
  width_t fw_q;
  word_t val_q;

  // after CALC
  width_t w_q;
  logic [START_W-1:0] start_q;
  logic [NEXT_W-1:0] next_q;

  // after CHECK
  logic st_q, rd_en_q, wr_en_q, hi_en_q;
  width_t rw_q;
  logic [OFS_W-1:0] ofs_q;
  logic [AW-1:0] wi_q, wi1_q;

  // RAM side
  word_t mem [NUM_WORDS];
  word_t mem_rdata_q;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  word_t mem_wdata;

  word_t lo_q, new_hi_q, rd_val_q;

  // ---------------------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q <= BITMAP_RESET;
      record_q <= RECORD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BITMAP_BITS:  bitmap_q <= cfg_wdata_i;
        CFG_RECORD_WIDTH: record_q <= cfg_wdata_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // CALC: clamp width, form start bit (bit index, or record index times width)
  width_t w_d;
  logic [START_W-1:0] start_d;
  logic [NEXT_W-1:0] next_d;

  always_comb begin
    if (type_q[1]) begin
      if (record_q == '0) begin
        w_d = width_t'(1);
      end else if (record_q > FULL_WIDTH) begin
        w_d = FULL_WIDTH;
      end else begin
        w_d = record_q;
      end
      start_d = START_W'(pos_q) * START_W'(w_d);
      next_d  = NEXT_W'(pos_q) + NEXT_W'(1);
    end else begin
      w_d     = (fw_q > FULL_WIDTH) ? FULL_WIDTH : fw_q;
      start_d = START_W'(pos_q);
      next_d  = NEXT_W'(pos_q) + NEXT_W'(w_d);
    end
  end

  // ---------------------------------------------------------------------------
  // CHECK: range test against the usable size, pick the words touched
  logic [SIZE_W-1:0] size;
  logic [END_W-1:0] end_bit, start_x, size_x;
  logic st_d, rd_en_d, wr_en_d, hi_en_d;
  width_t rw_d, span_w;
  logic [WI_W-1:0] wi_full;
  logic [OFS_W+1:0] reach;

  always_comb begin
    size    = (END_W'(bitmap_q) < CAP) ? bitmap_q : CAP[SIZE_W-1:0];
    size_x  = END_W'(size);
    start_x = END_W'(start_q);
    end_bit = start_x + END_W'(w_q);
    st_d    = 1'b0;
    rd_en_d = 1'b0;
    wr_en_d = 1'b0;
    rw_d    = w_q;
    if (!type_q[0]) begin
      if (w_q != '0) begin
        if (start_x >= size_x) begin
          st_d = 1'b1;
        end else begin
          rd_en_d = 1'b1;
          // cut the read short at the end of the store
          if (end_bit > size_x) begin
            rw_d = WIDTH_W'(size_x - start_x);
          end
        end
      end
    end else begin
      if (end_bit > size_x) begin
        st_d = 1'b1;
      end else if (w_q != '0) begin
        wr_en_d = 1'b1;
      end
    end
    span_w  = type_q[0] ? w_q : rw_d;
    reach   = (OFS_W + 2)'(start_q[OFS_W-1:0]) + (OFS_W + 2)'(span_w);
    wi_full = start_q[START_W-1:OFS_W];
    hi_en_d = (rd_en_d || wr_en_d) && (reach > (OFS_W + 2)'(WORD_W)) &&
              ((WI_W + 1)'(wi_full) + (WI_W + 1)'(1) < WC_CMP);
  end

  // ---------------------------------------------------------------------------
  // RD2: merge the two words, extract the read field, splice in the write field
  word_t hi_word;
  logic [2*WORD_W-1:0] pair, wmask2, wval2, merged, shifted;

  always_comb begin
    hi_word = hi_en_q ? mem_rdata_q : '0;
    pair    = {hi_word, lo_q};
    shifted = pair >> ofs_q;
    wmask2  = (2 * WORD_W)'(width_mask(w_q)) << ofs_q;
    wval2   = (2 * WORD_W)'(val_q & width_mask(w_q)) << ofs_q;
    merged  = (pair & ~wmask2) | wval2;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE:  if (start) state_d = ST_CALC;
      ST_CALC:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_WR1;
      ST_WR1:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_WR1);
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  // Datapath registers; hold between items
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          type_q <= req_type_i;
          pos_q  <= position_i;
          fw_q   <= field_width_i;
          val_q  <= write_value_i;
        end
      end
      ST_CALC: begin
        w_q     <= w_d;
        start_q <= start_d;
        next_q  <= next_d;
      end
      ST_CHECK: begin
        st_q    <= st_d;
        rd_en_q <= rd_en_d;
        wr_en_q <= wr_en_d;
        hi_en_q <= hi_en_d;
        rw_q    <= rw_d;
        ofs_q   <= start_q[OFS_W-1:0];
        wi_q    <= start_q[AW+OFS_W-1:OFS_W];
        wi1_q   <= start_q[AW+OFS_W-1:OFS_W] + AW'(1);
      end
      ST_RD1: lo_q <= mem_rdata_q;
      ST_RD2: begin
        rd_val_q <= rd_en_q ? (shifted[WORD_W-1:0] & width_mask(rw_q)) : '0;
        new_hi_q <= merged[2*WORD_W-1:WORD_W];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // RAM port: one access per cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = wi_q;
    mem_wdata = merged[WORD_W-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_CHECK: begin
        mem_re   = rd_en_d || wr_en_d;
        mem_addr = start_q[AW+OFS_W-1:OFS_W];
      end
      ST_RD1: begin
        mem_re   = hi_en_q;
        mem_addr = wi1_q;
      end
      ST_RD2: begin
        mem_we   = wr_en_q;
        mem_addr = wi_q;
      end
      ST_WR1: begin
        mem_we    = wr_en_q && hi_en_q;
        mem_addr  = wi1_q;
        mem_wdata = new_hi_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      mem_rdata_q <= mem[mem_addr];
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign read_value_o    = rd_val_q;
  assign next_position_o = next_q;
  assign status_o        = st_q;

  // ---------------------------------------------------------------------------
  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_after_wr1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_WR1)
    else $error("result strobe outside item end");

  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == ST_CALC)
    else $error("accepted request did not advance");

  a_no_write_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q && (state_q == ST_RD2 || state_q == ST_WR1)) |-> !mem_we)
    else $error("RAM written on out-of-range request");

  a_no_rw_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("RAM read and write in one cycle");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pbfs_pkg::*;

  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned WORD_BITS   = WORD_W;
  localparam int unsigned STORE_BITS  = STORE_WORDS * WORD_BITS;
  localparam int unsigned CLK_PERIOD  = 10;
  // Slowest legal run: ~1300 items plus long sender gaps,
  // plus the clearing pass after reset. Take it many times over.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned DIRECTED_ROWS = 24;
  localparam word_t       ALL_ONES    = ~word_t'(0);
  localparam logic        TYPED       = 1'b1;
  localparam logic        PREDICTED   = 1'b0;

  typedef struct packed {
    word_t             read_value;
    logic [NEXT_W-1:0] next_position;
    logic              status;
  } outcome_t;

  typedef struct packed {
    req_t             kind;
    logic [POS_W-1:0] pos;
    width_t           width;
    word_t            value;
    logic             known;
    outcome_t         result;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  req_t                req_type_i    = REQ_READ_FIELD;
  logic [POS_W-1:0]    position_i    = '0;
  width_t              field_width_i = '0;
  word_t               write_value_i = '0;
  logic                done_o;
  word_t               read_value_o;
  logic [NEXT_W-1:0]   next_position_o;
  logic                status_o;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = CFG_BITMAP_BITS;
  logic [SIZE_W-1:0]   cfg_wdata_i   = '0;

  // Typed expectation that travels with a directed request, driven alongside
  // the request so it is sampled at the same edge as the transfer.
  logic                row_known     = 1'b0;
  outcome_t            row_result    = '0;

  // Shadow copy of the store and its registers, advanced at transfers and writes.
  word_t               shadow_words [STORE_WORDS] = '{default: '0};
  logic [SIZE_W-1:0]   shadow_bitmap_bits  = BITMAP_RESET;
  logic [WIDTH_W-1:0]  shadow_record_width = RECORD_RESET;

  outcome_t            outcome_q [$];
  int unsigned         mismatches    = 0;
  int unsigned         cycle_count   = 0;
  int unsigned         sender_idle_pct = 0;

  // Driver-side view of the registers, used to aim random positions.
  int unsigned         cur_bits      = BITMAP_RESET;
  int unsigned         cur_rec       = RECORD_RESET;

  // Per-phase settings: size, record width, sender idle percentage, item count.
  // Size 0 and 1, a size past the store, record widths 0, 1, 64 and above 64.
  // Phases with no sender idling run back to back; the receiver is never
  // stalled, as this result port cannot be held off; the rest idle the sender.
  int unsigned phase_bits  [PHASES] = '{65536, 1000, 131071, 1, 0, 4097, 65535};
  int unsigned phase_rec   [PHASES] = '{64, 0, 127, 1, 65, 13, 7};
  int unsigned phase_idle  [PHASES] = '{0, 76, 11, 0, 76, 11, 0};
  int unsigned phase_items [PHASES] = '{250, 200, 200, 100, 100, 200, 200};

  // Directed requests under the reset settings: 65536-bit store, 8-bit records.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Fresh store reads as zero, full width from the first bit, one bit at the last.
    '{REQ_READ_FIELD,   16'd0,     7'd64,  64'd0,    TYPED, '{64'd0, 17'd64,    1'b0}},
    '{REQ_READ_FIELD,   16'd65535, 7'd1,   64'd0,    TYPED, '{64'd0, 17'd65536, 1'b0}},
    // Read that runs off the end is cut short, next position is not.
    '{REQ_READ_FIELD,   16'd65535, 7'd64,  64'd0,    TYPED, '{64'd0, 17'd65599, 1'b0}},
    // Zero-width read.
    '{REQ_READ_FIELD,   16'd300,   7'd0,   64'd0,    TYPED, '{64'd0, 17'd300,   1'b0}},
    // Write one bit past the end: flagged, store untouched.
    '{REQ_WRITE_FIELD,  16'd65535, 7'd2,   ALL_ONES, TYPED, '{64'd0, 17'd65537, 1'b1}},
    // Set the very last bit, then look at it.
    '{REQ_WRITE_FIELD,  16'd65535, 7'd1,   ALL_ONES, TYPED, '{64'd0, 17'd65536, 1'b0}},
    '{REQ_READ_FIELD,   16'd65472, 7'd64,  64'd0,    PREDICTED, '0},
    '{REQ_READ_FIELD,   16'd65535, 7'd64,  64'd0,    PREDICTED, '0},
    // Zero-width write.
    '{REQ_WRITE_FIELD,  16'd0,     7'd0,   ALL_ONES, TYPED, '{64'd0, 17'd0,     1'b0}},
    // Fields that straddle two words.
    '{REQ_WRITE_FIELD,  16'd60,    7'd8,   64'hA5,   PREDICTED, '0},
    '{REQ_READ_FIELD,   16'd56,    7'd16,  64'd0,    PREDICTED, '0},
    // Oversized field width is used as 64.
    '{REQ_WRITE_FIELD,  16'd128,   7'd127, 64'hFEDC_BA98_7654_3210, PREDICTED, '0},
    '{REQ_READ_FIELD,   16'd128,   7'd100, 64'd0,    PREDICTED, '0},
    '{REQ_READ_FIELD,   16'd129,   7'd64,  64'd0,    PREDICTED, '0},
    '{REQ_WRITE_FIELD,  16'd193,   7'd64,  ALL_ONES, PREDICTED, '0},
    '{REQ_READ_FIELD,   16'd192,   7'd64,  64'd0,    PREDICTED, '0},
    // Records: only the low record-width bits of the value land.
    '{REQ_WRITE_RECORD, 16'd3,     7'd127, 64'h1234, PREDICTED, '0},
    '{REQ_READ_RECORD,  16'd3,     7'd0,   64'd0,    PREDICTED, '0},
    '{REQ_READ_RECORD,  16'd65535, 7'd64,  64'd0,    TYPED, '{64'd0, 17'd65536, 1'b1}},
    // Last record that fits, then the first one that does not.
    '{REQ_WRITE_RECORD, 16'd8191,  7'd1,   ALL_ONES, PREDICTED, '0},
    '{REQ_WRITE_RECORD, 16'd8192,  7'd1,   ALL_ONES, TYPED, '{64'd0, 17'd8193,  1'b1}},
    '{REQ_READ_RECORD,  16'd8191,  7'd64,  64'd0,    PREDICTED, '0},
    '{REQ_READ_FIELD,   16'd65530, 7'd64,  64'd0,    PREDICTED, '0},
    // Full-width write that ends exactly at the end of the store.
    '{REQ_WRITE_FIELD,  16'd65472, 7'd64,  ALL_ONES, PREDICTED, '0}
  };

  packed_bit_field_store #(
    .NUM_WORDS(STORE_WORDS)
  ) DUT (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_type_i,
    .position_i,
    .field_width_i,
    .write_value_i,
    .done_o,
    .read_value_o,
    .next_position_o,
    .status_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic word_t low_ones(input int unsigned w);
    return (w >= WORD_BITS) ? ALL_ONES : ((word_t'(1) << w) - word_t'(1));
  endfunction

  // Work out the result of one request and apply it to the shadow store.
  function automatic outcome_t apply_request(input req_t kind,
                                             input logic [POS_W-1:0] pos,
                                             input width_t fw,
                                             input word_t val);
    outcome_t    o;
    int unsigned limit;
    int unsigned w;
    int unsigned first;
    int unsigned span;
    int unsigned wi;
    int unsigned b;
    word_t       m;
    word_t       v;
    o = '0;
    // Clip the configured size to what the store holds.
    limit = (shadow_bitmap_bits > STORE_BITS) ? STORE_BITS : shadow_bitmap_bits;
    if (kind == REQ_READ_RECORD || kind == REQ_WRITE_RECORD) begin
      w = shadow_record_width;
      if (w == 0) w = 1;
      if (w > WORD_BITS) w = WORD_BITS;
      first = pos * w;
      o.next_position = NEXT_W'(pos + 1);
    end else begin
      w = (fw > FULL_WIDTH) ? WORD_BITS : fw;
      first = pos;
      o.next_position = NEXT_W'(pos + w);
    end
    if (kind == REQ_READ_FIELD || kind == REQ_READ_RECORD) begin
      if (w != 0) begin
        if (first >= limit) begin
          o.status = 1'b1;
        end else begin
          // Drop the bits past the end of the store.
          span = (first + w > limit) ? limit - first : w;
          wi = first >> 6;
          b = first & 63;
          v = shadow_words[wi] >> b;
          if (b != 0 && b + span > WORD_BITS && wi + 1 < STORE_WORDS) begin
            v |= shadow_words[wi + 1] << (WORD_BITS - b);
          end
          o.read_value = v & low_ones(span);
        end
      end
    end else if (first + w > limit) begin
      o.status = 1'b1;
    end else if (w != 0) begin
      wi = first >> 6;
      b = first & 63;
      m = low_ones(w);
      v = val & m;
      shadow_words[wi] = (shadow_words[wi] & ~(m << b)) | (v << b);
      if (b + w > WORD_BITS && wi + 1 < STORE_WORDS) begin
        shadow_words[wi + 1] = (shadow_words[wi + 1] & ~(m >> (WORD_BITS - b))) |
                               (v >> (WORD_BITS - b));
      end
    end
    return o;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input int p);
    if (p < 0) return '0;
    if (p > 65535) return '1;
    return p[POS_W-1:0];
  endfunction

  // Result check, transfer capture and register shadowing share one process
  // so that everything seen at an edge is the value from before that edge.
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    outcome_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value_o);
            mismatches++;
          end
          if (next_position_o !== want.next_position) begin
            $error("next_position: expected %0d, got %0d",
                   want.next_position, next_position_o);
            mismatches++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        // Always advance the shadow store; hold the typed value where given.
        predicted = apply_request(req_type_i, position_i, field_width_i, write_value_i);
        outcome_q.push_back(row_known ? row_result : predicted);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BITMAP_BITS) begin
          shadow_bitmap_bits = cfg_wdata_i;
        end else begin
          shadow_record_width = cfg_wdata_i[WIDTH_W-1:0];
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL packed_bit_field_store");
      $finish;
    end
  end

  // Present one request after a random gap and hold it until it transfers.
  // Start is left high afterwards; the next call drops or reuses it.
  task automatic issue(input req_t kind, input logic [POS_W-1:0] pos,
                       input width_t fw, input word_t val,
                       input logic known, input outcome_t result);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    req_type_i    <= kind;
    position_i    <= pos;
    field_width_i <= fw;
    write_value_i <= val;
    row_known     <= known;
    row_result    <= result;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every result is in and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (outcome_q.size() != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned bits, input int unsigned rec);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BITMAP_BITS;
    cfg_wdata_i <= SIZE_W'(bits);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RECORD_WIDTH;
    cfg_wdata_i <= SIZE_W'(rec);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_bits = bits;
    cur_rec  = rec;
  endtask

  // Random request aimed at the start of the store, the end of the store and
  // word boundaries, so that reads see earlier writes and edges get hit.
  task automatic random_request();
    int unsigned      limit;
    int unsigned      rec_w;
    int unsigned      rec_count;
    int unsigned      pick;
    req_t             kind;
    logic [POS_W-1:0] pos;
    width_t           fw;
    word_t            val;
    limit = (cur_bits > STORE_BITS) ? STORE_BITS : cur_bits;
    rec_w = (cur_rec == 0) ? 1 : ((cur_rec > WORD_BITS) ? WORD_BITS : cur_rec);
    rec_count = limit / rec_w;
    kind = req_t'($urandom_range(0, 3));

    pick = $urandom_range(99);
    if (kind == REQ_READ_RECORD || kind == REQ_WRITE_RECORD) begin
      if (pick < 50) pos = clamp_pos($urandom_range(0, 600 / rec_w + 1));
      else if (pick < 80) pos = clamp_pos(int'(rec_count) - 3 + int'($urandom_range(0, 6)));
      else pos = POS_W'($urandom_range(0, 65535));
    end else begin
      if (pick < 40) pos = clamp_pos($urandom_range(0, 599));
      else if (pick < 75) pos = clamp_pos(int'(limit) - 600 + int'($urandom_range(0, 670)));
      else if (pick < 85) pos = clamp_pos(($urandom_range(0, 9) << 6) + 60 +
                                          $urandom_range(0, 7));
      else pos = POS_W'($urandom_range(0, 65535));
    end

    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(0, 3))
        0: fw = 7'd0;
        1: fw = 7'd1;
        2: fw = 7'd63;
        default: fw = 7'd64;
      endcase
    end else if (pick < 25) begin
      fw = WIDTH_W'($urandom_range(65, 127));
    end else begin
      fw = WIDTH_W'($urandom_range(0, 64));
    end

    pick = $urandom_range(99);
    if (pick < 10) val = '0;
    else if (pick < 20) val = ALL_ONES;
    else val = {$urandom, $urandom};

    issue(kind, pos, fw, val, PREDICTED, '0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset settings, back to back.
    sender_idle_pct = 0;
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].width,
            directed_rows[i].value, directed_rows[i].known, directed_rows[i].result);
    end

    // Random phases; reprogram only once the block has drained.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      configure(phase_bits[ph], phase_rec[ph]);
      sender_idle_pct = phase_idle[ph];
      for (int n = 0; n < phase_items[ph]; n++) begin
        random_request();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("PASS packed_bit_field_store");
    end else begin
      $display("FAIL packed_bit_field_store");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pbfs_pkg.sv
design/packed_bit_field_store.sv
verif/tb_top.sv
